>>> sv/assert_macros.svh
// Assertion macros shared by the ray/sphere intersection RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, masked while reset is held.
`define RSI_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("ray_sphere_intersect: assertion failed");

// Checked property, also active during reset.
`define RSI_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("ray_sphere_intersect: reset assertion failed");

`endif

>>> sv/rsi_pkg.sv
// Shared widths, types and register codes for the ray/sphere intersection block.
package rsi_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int COORD_WIDTH = 32;

    localparam int CW     = COORD_WIDTH;     // coordinate / t field
    localparam int RADW   = CW - 1;          // radius register
    localparam int PW     = CW + 1;          // origin - centre
    localparam int DPKW   = 2 * CW + 1;      // one d*p term
    localparam int DDW    = 2 * CW;          // d.d, unsigned
    localparam int PPW    = 2 * CW + 2;      // one p*p term
    localparam int R2W    = 2 * RADW;        // r^2
    localparam int DPW    = 2 * CW + 3;      // d.p and p.p - r^2, signed
    localparam int MAGW   = 2 * CW + 2;      // multiplier operand
    localparam int MUL_HW = MAGW / 2;        // multiplier limb
    localparam int PRW    = 2 * MAGW;        // wide products, discriminant
    localparam int SQW    = PRW / 2;         // square root
    localparam int SRW    = SQW + 2;         // square root remainder
    localparam int NUMW   = SQW + 1;         // |-d.p -/+ s|
    localparam int TQW    = CW + 1;          // quotient bits kept
    localparam int TW     = CW + 3;          // signed t before range check
    localparam int EXW    = NUMW + FRAC_BITS; // scaled numerator
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_CENTER_Z = 2'd2,
        CFG_RADIUS   = 2'd3
    } t_cfg_idx;

    typedef logic signed [PW-1:0]    t_p;
    typedef logic signed [DPKW-1:0]  t_dpk;
    typedef logic signed [DDW-1:0]   t_dds;
    typedef logic [DDW-1:0]          t_dd;
    typedef logic signed [PPW-1:0]   t_pps;
    typedef logic [R2W-1:0]          t_r2;
    typedef logic signed [DPW-1:0]   t_dp;
    typedef logic [MAGW-1:0]         t_mag;
    typedef logic [2*MUL_HW-1:0]     t_mulp;
    typedef logic [PRW-1:0]          t_prod;
    typedef logic signed [PRW:0]     t_dsc;
    typedef logic [SRW-1:0]          t_srem;
    typedef logic signed [NUMW:0]    t_n;
    typedef logic [NUMW-1:0]         t_nmag;
    typedef logic signed [TW-1:0]    t_t;

    typedef struct packed {
        logic                 ok;
        logic signed [DPW-1:0] dp;
        logic [DDW-1:0]       dd;
        logic signed [CW-1:0] lo;
        logic signed [CW-1:0] hi;
    } t_sq_side;

    typedef struct packed {
        logic                 ok;
        logic signed [CW-1:0] lo;
        logic signed [CW-1:0] hi;
    } t_div_side;

    typedef struct packed {
        logic           ovf;
        logic           neg;
        logic           rem_nz;
        logic [TQW-1:0] q;
    } t_quot;

endpackage

>>> sv/ray_sphere_intersect.sv
// Top level: ray/sphere intersection pipeline with configuration registers.
// One ray is taken per clock while the result side is not holding, and each gives exactly
// one result. The square root has 66 stages (one root bit each) and the divider one
// scaling stage plus 33 stages (one quotient bit each, both roots side by side); the dot
// products, the wide products and the discriminant take seven stages in front, one stage
// between root and divider forms the two numerators, and the root select takes two behind.
// The whole pipe advances together: it moves when the output register is empty or its
// beat is taken, so ready is high whenever the result side is not holding. Sphere registers
// are read as rays pass through, so write them only with no ray in flight.
`include "assert_macros.svh"

module ray_sphere_intersect (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [rsi_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [rsi_pkg::CW-1:0]               i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [rsi_pkg::CW-1:0]        i_origin_x,
    input  logic signed [rsi_pkg::CW-1:0]        i_origin_y,
    input  logic signed [rsi_pkg::CW-1:0]        i_origin_z,
    input  logic signed [rsi_pkg::CW-1:0]        i_dir_x,
    input  logic signed [rsi_pkg::CW-1:0]        i_dir_y,
    input  logic signed [rsi_pkg::CW-1:0]        i_dir_z,
    input  logic signed [rsi_pkg::CW-1:0]        i_t_min,
    input  logic signed [rsi_pkg::CW-1:0]        i_t_max,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_hit_valid,
    output logic signed [rsi_pkg::CW-1:0]        o_hit_t
);

    // configuration
    logic signed [rsi_pkg::CW-1:0]   r_center_x, r_center_y, r_center_z;
    logic [rsi_pkg::RADW-1:0]        r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_center_z <= '0;
            r_radius   <= rsi_pkg::RADW'(1) << rsi_pkg::FRAC_BITS;
        end else if (i_cfg_we) begin
            unique case (rsi_pkg::t_cfg_idx'(i_cfg_idx))
                rsi_pkg::CFG_CENTER_X: r_center_x <= i_cfg_data;
                rsi_pkg::CFG_CENTER_Y: r_center_y <= i_cfg_data;
                rsi_pkg::CFG_CENTER_Z: r_center_z <= i_cfg_data;
                rsi_pkg::CFG_RADIUS:   r_radius   <= i_cfg_data[rsi_pkg::RADW-1:0];
                default: ;
            endcase
        end
    end

    logic w_ce;
    logic r_o_valid;
    logic r_hit;
    logic signed [rsi_pkg::CW-1:0] r_hit_t;

    assign w_ce    = !r_o_valid || i_ready;
    assign o_ready = w_ce;

    // stage 1: p = origin - centre
    logic signed [rsi_pkg::CW-1:0] w_o [0:2];
    logic signed [rsi_pkg::CW-1:0] w_c [0:2];
    logic signed [rsi_pkg::CW-1:0] w_d [0:2];

    assign w_o[0] = i_origin_x;
    assign w_o[1] = i_origin_y;
    assign w_o[2] = i_origin_z;
    assign w_c[0] = r_center_x;
    assign w_c[1] = r_center_y;
    assign w_c[2] = r_center_z;
    assign w_d[0] = i_dir_x;
    assign w_d[1] = i_dir_y;
    assign w_d[2] = i_dir_z;

    logic                          r_v1;
    rsi_pkg::t_p                   r_p1 [0:2];
    logic signed [rsi_pkg::CW-1:0] r_d1 [0:2];
    logic signed [rsi_pkg::CW-1:0] r_lo1, r_hi1;

    // stage 2: per-axis products and r^2
    logic                          r_v2;
    rsi_pkg::t_dpk                 r_dpk2 [0:2];
    rsi_pkg::t_dd                  r_ddk2 [0:2];
    rsi_pkg::t_pps                 r_ppk2 [0:2];
    rsi_pkg::t_r2                  r_r2_2;
    logic signed [rsi_pkg::CW-1:0] r_lo2, r_hi2;

    // stage 3: sums
    logic                          r_v3;
    rsi_pkg::t_dp                  r_dp3, r_q3;
    rsi_pkg::t_dd                  r_dd3;
    logic signed [rsi_pkg::CW-1:0] r_lo3, r_hi3;

    // stage 4: magnitudes for the wide multipliers
    logic                          r_v4;
    rsi_pkg::t_mag                 r_dpmag4, r_qmag4;
    logic                          r_qneg4;
    rsi_pkg::t_sq_side             r_s4;

    // stages 5, 6: alongside the multipliers
    logic                          r_v5, r_v6;
    logic                          r_qneg5, r_qneg6;
    rsi_pkg::t_sq_side             r_s5, r_s6;
    rsi_pkg::t_prod                w_sq, w_pr;

    // stage 7: discriminant
    rsi_pkg::t_dsc                 w_disc;
    logic                          r_v7;
    rsi_pkg::t_prod                r_disc7;
    rsi_pkg::t_sq_side             r_s7;

    always_comb begin
        if (r_qneg6) begin
            w_disc = rsi_pkg::t_dsc'(w_sq) + rsi_pkg::t_dsc'(w_pr);
        end else begin
            w_disc = rsi_pkg::t_dsc'(w_sq) - rsi_pkg::t_dsc'(w_pr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (w_ce) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int k = 0; k < 3; k++) begin
                r_p1[k]   <= rsi_pkg::t_p'(w_o[k]) - rsi_pkg::t_p'(w_c[k]);
                r_d1[k]   <= w_d[k];
                r_dpk2[k] <= rsi_pkg::t_dpk'(r_d1[k]) * rsi_pkg::t_dpk'(r_p1[k]);
                r_ddk2[k] <= $unsigned(rsi_pkg::t_dds'(r_d1[k]) * rsi_pkg::t_dds'(r_d1[k]));
                r_ppk2[k] <= rsi_pkg::t_pps'(r_p1[k]) * rsi_pkg::t_pps'(r_p1[k]);
            end
            r_lo1  <= i_t_min;
            r_hi1  <= i_t_max;
            r_r2_2 <= rsi_pkg::t_r2'(r_radius) * rsi_pkg::t_r2'(r_radius);
            r_lo2  <= r_lo1;
            r_hi2  <= r_hi1;

            r_dp3 <= rsi_pkg::t_dp'(r_dpk2[0]) + rsi_pkg::t_dp'(r_dpk2[1])
                   + rsi_pkg::t_dp'(r_dpk2[2]);
            r_dd3 <= r_ddk2[0] + r_ddk2[1] + r_ddk2[2];
            r_q3  <= rsi_pkg::t_dp'(r_ppk2[0]) + rsi_pkg::t_dp'(r_ppk2[1])
                   + rsi_pkg::t_dp'(r_ppk2[2]) - rsi_pkg::t_dp'(r_r2_2);
            r_lo3 <= r_lo2;
            r_hi3 <= r_hi2;

            r_dpmag4 <= r_dp3[rsi_pkg::DPW-1] ? rsi_pkg::t_mag'(-r_dp3) : rsi_pkg::t_mag'(r_dp3);
            r_qmag4  <= r_q3[rsi_pkg::DPW-1] ? rsi_pkg::t_mag'(-r_q3) : rsi_pkg::t_mag'(r_q3);
            r_qneg4  <= r_q3[rsi_pkg::DPW-1];
            r_s4     <= '{ok: (r_dd3 != '0), dp: r_dp3, dd: r_dd3, lo: r_lo3, hi: r_hi3};

            r_qneg5 <= r_qneg4;
            r_s5    <= r_s4;
            r_qneg6 <= r_qneg5;
            r_s6    <= r_s5;

            // a negative discriminant is a miss; feed the root a zero instead
            r_disc7 <= w_disc[rsi_pkg::PRW] ? '0 : w_disc[rsi_pkg::PRW-1:0];
            r_s7    <= '{ok: r_s6.ok && !w_disc[rsi_pkg::PRW], dp: r_s6.dp, dd: r_s6.dd,
                         lo: r_s6.lo, hi: r_s6.hi};
        end
    end

    rsi_mul u_mul_sq (
        .i_clk (i_clk),
        .i_ce  (w_ce),
        .i_a   (r_dpmag4),
        .i_b   (r_dpmag4),
        .o_p   (w_sq)
    );

    rsi_mul u_mul_pr (
        .i_clk (i_clk),
        .i_ce  (w_ce),
        .i_a   (rsi_pkg::t_mag'(r_s4.dd)),
        .i_b   (r_qmag4),
        .o_p   (w_pr)
    );

    // square root
    logic                          w_sv;
    logic [rsi_pkg::SQW-1:0]       w_root;
    rsi_pkg::t_sq_side             w_sside;

    rsi_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_vld   (r_v7),
        .i_rad   (r_disc7),
        .i_side  (r_s7),
        .o_vld   (w_sv),
        .o_root  (w_root),
        .o_side  (w_sside)
    );

    // numerators -d.p - s and -d.p + s, as sign and magnitude
    rsi_pkg::t_n                   w_ndp, w_n1, w_n2;
    logic                          r_v8;
    logic [1:0][rsi_pkg::NUMW-1:0] r_n8;
    logic [1:0]                    r_neg8;
    rsi_pkg::t_dd                  r_dd8;
    rsi_pkg::t_div_side            r_ds8;

    assign w_ndp = -rsi_pkg::t_n'(w_sside.dp);
    assign w_n1  = w_ndp - rsi_pkg::t_n'(w_root);
    assign w_n2  = w_ndp + rsi_pkg::t_n'(w_root);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v8 <= 1'b0;
        end else if (w_ce) begin
            r_v8 <= w_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_n8[0]   <= w_n1[rsi_pkg::NUMW] ? rsi_pkg::t_nmag'(-w_n1) : rsi_pkg::t_nmag'(w_n1);
            r_n8[1]   <= w_n2[rsi_pkg::NUMW] ? rsi_pkg::t_nmag'(-w_n2) : rsi_pkg::t_nmag'(w_n2);
            r_neg8[0] <= w_n1[rsi_pkg::NUMW];
            r_neg8[1] <= w_n2[rsi_pkg::NUMW];
            r_dd8     <= w_sside.dd;
            r_ds8     <= '{ok: w_sside.ok, lo: w_sside.lo, hi: w_sside.hi};
        end
    end

    // divide both numerators by d.d
    logic                          w_dv;
    rsi_pkg::t_quot [1:0]          w_quot;
    rsi_pkg::t_div_side            w_dside;

    rsi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_vld   (r_v8),
        .i_num   (r_n8),
        .i_neg   (r_neg8),
        .i_dd    (r_dd8),
        .i_side  (r_ds8),
        .o_vld   (w_dv),
        .o_quot  (w_quot),
        .o_side  (w_dside)
    );

    // floor for negative quotients
    rsi_pkg::t_t                   w_qx  [0:1];
    rsi_pkg::t_t                   w_tq  [0:1];
    logic                          r_v9;
    rsi_pkg::t_t                   r_t9  [0:1];
    logic                          r_ovf9 [0:1];
    rsi_pkg::t_div_side            r_ds9;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_qx[l] = rsi_pkg::t_t'(w_quot[l].q) + rsi_pkg::t_t'(w_quot[l].rem_nz);
            w_tq[l] = w_quot[l].neg ? -w_qx[l] : rsi_pkg::t_t'(w_quot[l].q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v9 <= 1'b0;
        end else if (w_ce) begin
            r_v9 <= w_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int l = 0; l < 2; l++) begin
                r_t9[l]   <= w_tq[l];
                r_ovf9[l] <= w_quot[l].ovf;
            end
            r_ds9 <= w_dside;
        end
    end

    // range check and root select into the output register
    rsi_pkg::t_t w_lo, w_hi;
    logic        w_in [0:1];
    logic        n_hit;
    logic signed [rsi_pkg::CW-1:0] n_hit_t;

    assign w_lo = rsi_pkg::t_t'(r_ds9.lo);
    assign w_hi = rsi_pkg::t_t'(r_ds9.hi);

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_in[l] = !r_ovf9[l] && (r_t9[l] >= w_lo) && (r_t9[l] <= w_hi);
        end
        n_hit = r_ds9.ok && (w_in[0] || w_in[1]);
        if (!r_ds9.ok) begin
            n_hit_t = '0;
        end else if (w_in[0]) begin
            n_hit_t = r_t9[0][rsi_pkg::CW-1:0];
        end else if (w_in[1]) begin
            n_hit_t = r_t9[1][rsi_pkg::CW-1:0];
        end else begin
            n_hit_t = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_ce) begin
            r_o_valid <= r_v9;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_hit   <= n_hit;
            r_hit_t <= n_hit_t;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_hit_valid = r_hit;
    assign o_hit_t     = r_hit_t;

    `RSI_ASSERT(a_miss_t_zero, o_valid && !o_hit_valid |-> o_hit_t == '0)
    `RSI_ASSERT(a_both_ovf_miss, w_ce && r_v9 && r_ovf9[0] && r_ovf9[1] |=> o_valid && !o_hit_valid)
    `RSI_ASSERT(a_bad_ray_miss, w_ce && r_v9 && !r_ds9.ok |=> o_valid && !o_hit_valid)
    `RSI_ASSERT_RST(a_reset_clears, !i_rst_n |=> !o_valid)

endmodule

>>> sv/rsi_mul.sv
// Two-stage unsigned wide multiplier built from four limb products.
module rsi_mul (
    input  logic                      i_clk,
    input  logic                      i_ce,
    input  logic [rsi_pkg::MAGW-1:0]  i_a,
    input  logic [rsi_pkg::MAGW-1:0]  i_b,
    output logic [rsi_pkg::PRW-1:0]   o_p
);

    rsi_pkg::t_mulp r_ll, r_lh, r_hl, r_hh;
    rsi_pkg::t_prod r_p;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_ll <= rsi_pkg::t_mulp'(i_a[rsi_pkg::MUL_HW-1:0])
                  * rsi_pkg::t_mulp'(i_b[rsi_pkg::MUL_HW-1:0]);
            r_lh <= rsi_pkg::t_mulp'(i_a[rsi_pkg::MUL_HW-1:0])
                  * rsi_pkg::t_mulp'(i_b[rsi_pkg::MAGW-1:rsi_pkg::MUL_HW]);
            r_hl <= rsi_pkg::t_mulp'(i_a[rsi_pkg::MAGW-1:rsi_pkg::MUL_HW])
                  * rsi_pkg::t_mulp'(i_b[rsi_pkg::MUL_HW-1:0]);
            r_hh <= rsi_pkg::t_mulp'(i_a[rsi_pkg::MAGW-1:rsi_pkg::MUL_HW])
                  * rsi_pkg::t_mulp'(i_b[rsi_pkg::MAGW-1:rsi_pkg::MUL_HW]);
            r_p  <= (rsi_pkg::t_prod'(r_hh) << (2 * rsi_pkg::MUL_HW))
                  + ((rsi_pkg::t_prod'(r_lh) + rsi_pkg::t_prod'(r_hl)) << rsi_pkg::MUL_HW)
                  + rsi_pkg::t_prod'(r_ll);
        end
    end

    assign o_p = r_p;

endmodule

>>> sv/rsi_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module rsi_sqrt (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_ce,
    input  logic                     i_vld,
    input  logic [rsi_pkg::PRW-1:0]  i_rad,
    input  rsi_pkg::t_sq_side        i_side,
    output logic                     o_vld,
    output logic [rsi_pkg::SQW-1:0]  o_root,
    output rsi_pkg::t_sq_side        o_side
);

    logic                     w_vld  [0:rsi_pkg::SQW-1];
    logic [rsi_pkg::SRW-1:0]  w_rem  [0:rsi_pkg::SQW-1];
    logic [rsi_pkg::SQW-1:0]  w_root [0:rsi_pkg::SQW-1];
    logic [rsi_pkg::PRW-1:0]  w_rad  [0:rsi_pkg::SQW-1];
    rsi_pkg::t_sq_side        w_side [0:rsi_pkg::SQW-1];

    logic                     r_vld  [0:rsi_pkg::SQW-1];
    logic [rsi_pkg::SRW-1:0]  r_rem  [0:rsi_pkg::SQW-1];
    logic [rsi_pkg::SQW-1:0]  r_root [0:rsi_pkg::SQW-1];
    logic [rsi_pkg::PRW-1:0]  r_rad  [0:rsi_pkg::SQW-1];
    rsi_pkg::t_sq_side        r_side [0:rsi_pkg::SQW-1];

    genvar k;
    for (k = 0; k < rsi_pkg::SQW; k++) begin : g_stage
        logic [rsi_pkg::SRW+1:0] cur;
        logic [rsi_pkg::SRW+1:0] trial;
        logic                    ge;

        if (k == 0) begin : g_first
            assign w_vld[k]  = i_vld;
            assign w_rem[k]  = '0;
            assign w_root[k] = '0;
            assign w_rad[k]  = i_rad;
            assign w_side[k] = i_side;
        end else begin : g_next
            assign w_vld[k]  = r_vld[k-1];
            assign w_rem[k]  = r_rem[k-1];
            assign w_root[k] = r_root[k-1];
            assign w_rad[k]  = r_rad[k-1];
            assign w_side[k] = r_side[k-1];
        end

        // bring down the next radicand bit pair, try root*4+1
        always_comb begin
            cur   = {w_rem[k], w_rad[k][rsi_pkg::PRW-1 -: 2]};
            trial = {2'b00, w_root[k], 2'b01};
            ge    = (cur >= trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_ce) begin
                r_vld[k] <= w_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[k]  <= ge ? rsi_pkg::t_srem'(cur - trial) : rsi_pkg::t_srem'(cur);
                r_root[k] <= {w_root[k][rsi_pkg::SQW-2:0], ge};
                r_rad[k]  <= w_rad[k] << 2;
                r_side[k] <= w_side[k];
            end
        end
    end

    assign o_vld  = r_vld[rsi_pkg::SQW-1];
    assign o_root = r_root[rsi_pkg::SQW-1];
    assign o_side = r_side[rsi_pkg::SQW-1];

endmodule

>>> sv/rsi_div.sv
// Two-lane pipelined restoring divider sharing one divisor, one quotient bit per stage.
module rsi_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_ce,
    input  logic                                i_vld,
    input  logic [1:0][rsi_pkg::NUMW-1:0]       i_num,
    input  logic [1:0]                          i_neg,
    input  logic [rsi_pkg::DDW-1:0]             i_dd,
    input  rsi_pkg::t_div_side                  i_side,
    output logic                                o_vld,
    output rsi_pkg::t_quot [1:0]                o_quot,
    output rsi_pkg::t_div_side                  o_side
);

    // prep stage: scale numerator, catch quotients too large to keep
    logic [rsi_pkg::EXW-1:0]  w_ext [0:1];
    logic                     w_ovf [0:1];

    logic                     r_pvld;
    rsi_pkg::t_div_side       r_pside;
    logic [rsi_pkg::DDW-1:0]  r_pdd;
    logic [rsi_pkg::DDW-1:0]  r_prem  [0:1];
    logic [rsi_pkg::TQW-1:0]  r_pbits [0:1];
    logic                     r_povf  [0:1];
    logic                     r_pneg  [0:1];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_ext[l] = {i_num[l], {rsi_pkg::FRAC_BITS{1'b0}}};
            w_ovf[l] = (w_ext[l][rsi_pkg::EXW-1:rsi_pkg::TQW] >= i_dd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else if (i_ce) begin
            r_pvld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_pside <= i_side;
            r_pdd   <= i_dd;
            for (int l = 0; l < 2; l++) begin
                r_prem[l]  <= w_ovf[l] ? '0
                            : rsi_pkg::t_dd'(w_ext[l][rsi_pkg::EXW-1:rsi_pkg::TQW]);
                r_pbits[l] <= w_ext[l][rsi_pkg::TQW-1:0];
                r_povf[l]  <= w_ovf[l];
                r_pneg[l]  <= i_neg[l];
            end
        end
    end

    logic                     w_vld  [0:rsi_pkg::TQW-1];
    rsi_pkg::t_div_side       w_side [0:rsi_pkg::TQW-1];
    logic [rsi_pkg::DDW-1:0]  w_dd   [0:rsi_pkg::TQW-1];
    logic [rsi_pkg::DDW-1:0]  w_rem  [0:rsi_pkg::TQW-1][0:1];
    logic [rsi_pkg::TQW-1:0]  w_bits [0:rsi_pkg::TQW-1][0:1];
    logic [rsi_pkg::TQW-1:0]  w_q    [0:rsi_pkg::TQW-1][0:1];
    logic                     w_ovf2 [0:rsi_pkg::TQW-1][0:1];
    logic                     w_neg  [0:rsi_pkg::TQW-1][0:1];

    logic                     r_vld  [0:rsi_pkg::TQW-1];
    rsi_pkg::t_div_side       r_side [0:rsi_pkg::TQW-1];
    logic [rsi_pkg::DDW-1:0]  r_dd   [0:rsi_pkg::TQW-1];
    logic [rsi_pkg::DDW-1:0]  r_rem  [0:rsi_pkg::TQW-1][0:1];
    logic [rsi_pkg::TQW-1:0]  r_bits [0:rsi_pkg::TQW-1][0:1];
    logic [rsi_pkg::TQW-1:0]  r_q    [0:rsi_pkg::TQW-1][0:1];
    logic                     r_ovf  [0:rsi_pkg::TQW-1][0:1];
    logic                     r_neg  [0:rsi_pkg::TQW-1][0:1];

    genvar k, m;
    for (k = 0; k < rsi_pkg::TQW; k++) begin : g_stage
        if (k == 0) begin : g_first
            assign w_vld[k]  = r_pvld;
            assign w_side[k] = r_pside;
            assign w_dd[k]   = r_pdd;
        end else begin : g_next
            assign w_vld[k]  = r_vld[k-1];
            assign w_side[k] = r_side[k-1];
            assign w_dd[k]   = r_dd[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_ce) begin
                r_vld[k] <= w_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_side[k] <= w_side[k];
                r_dd[k]   <= w_dd[k];
            end
        end

        for (m = 0; m < 2; m++) begin : g_lane
            logic [rsi_pkg::DDW:0] cur;
            logic                  ge;

            if (k == 0) begin : g_first
                assign w_rem[k][m]  = r_prem[m];
                assign w_bits[k][m] = r_pbits[m];
                assign w_q[k][m]    = '0;
                assign w_ovf2[k][m] = r_povf[m];
                assign w_neg[k][m]  = r_pneg[m];
            end else begin : g_next
                assign w_rem[k][m]  = r_rem[k-1][m];
                assign w_bits[k][m] = r_bits[k-1][m];
                assign w_q[k][m]    = r_q[k-1][m];
                assign w_ovf2[k][m] = r_ovf[k-1][m];
                assign w_neg[k][m]  = r_neg[k-1][m];
            end

            always_comb begin
                cur = {w_rem[k][m], w_bits[k][m][rsi_pkg::TQW-1]};
                ge  = (cur >= {1'b0, w_dd[k]});
            end

            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_rem[k][m]  <= ge ? rsi_pkg::t_dd'(cur - {1'b0, w_dd[k]})
                                       : rsi_pkg::t_dd'(cur);
                    r_bits[k][m] <= w_bits[k][m] << 1;
                    r_q[k][m]    <= {w_q[k][m][rsi_pkg::TQW-2:0], ge};
                    r_ovf[k][m]  <= w_ovf2[k][m];
                    r_neg[k][m]  <= w_neg[k][m];
                end
            end

            assign o_quot[m] = '{ovf:    r_ovf[rsi_pkg::TQW-1][m],
                                 neg:    r_neg[rsi_pkg::TQW-1][m],
                                 rem_nz: (r_rem[rsi_pkg::TQW-1][m] != '0),
                                 q:      r_q[rsi_pkg::TQW-1][m]};
        end
    end

    assign o_vld  = r_vld[rsi_pkg::TQW-1];
    assign o_side = r_side[rsi_pkg::TQW-1];

endmodule

>>> test/ray_sphere_intersect_test.sv
// Stream testbench for ray_sphere_intersect: random and aimed rays checked against an exact predictor.
module ray_sphere_intersect_test;

    localparam int WD_LIMIT = 3000;

    typedef logic signed [259:0] t_wint;
    typedef logic signed [rsi_pkg::CW-1:0] t_coord;

    typedef struct {
        t_coord ox, oy, oz, dx, dy, dz, tmin, tmax;
    } t_ray;

    typedef struct {
        bit     hit;
        t_coord t;
    } t_hit;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [rsi_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [rsi_pkg::CW-1:0] i_cfg_data = '0;
    logic i_valid = 0;
    logic o_ready;
    t_coord i_origin_x = 0, i_origin_y = 0, i_origin_z = 0;
    t_coord i_dir_x = 0, i_dir_y = 0, i_dir_z = 0;
    t_coord i_t_min = 0, i_t_max = 0;
    logic o_valid;
    logic i_ready = 0;
    logic o_hit_valid;
    t_coord o_hit_t;

    ray_sphere_intersect dut (.*);

    // sphere as the block should hold it
    t_coord sph_cx = 0, sph_cy = 0, sph_cz = 0;
    logic [rsi_pkg::RADW-1:0] sph_r = 31'd65536;

    t_ray pending_rays[$];
    t_hit expected_hits[$];
    int   errors = 0;
    int   tx_gap = 0;
    int   rx_gap = 0;
    int   hold_left = 0;
    int   idle_cycles = 0;
    bit   quiet = 0;
    bit   hold_req = 0;
    bit   hold_done = 0;

    initial forever #4 i_clk = ~i_clk;

    function automatic t_wint int_sqrt(t_wint a);
        t_wint r, c;
        r = 0;
        for (int i = 127; i >= 0; i--) begin
            c = r | (t_wint'(1) <<< i);
            if (c * c <= a) r = c;
        end
        return r;
    endfunction

    function automatic t_wint floor_div(t_wint n, t_wint d);
        t_wint q;
        q = n / d;
        if (n < 0 && (n % d) != 0) q = q - 1;
        return q;
    endfunction

    function automatic t_hit sphere_hit(t_ray r);
        t_wint px, py, pz, dx, dy, dz, dp, dd, pp, r2, disc, s, t, lo, hi;
        t_hit h;
        h.hit = 0;
        h.t = 0;
        px = t_wint'(r.ox) - t_wint'(sph_cx);
        py = t_wint'(r.oy) - t_wint'(sph_cy);
        pz = t_wint'(r.oz) - t_wint'(sph_cz);
        dx = t_wint'(r.dx);
        dy = t_wint'(r.dy);
        dz = t_wint'(r.dz);
        lo = t_wint'(r.tmin);
        hi = t_wint'(r.tmax);
        dp = dx * px + dy * py + dz * pz;
        dd = dx * dx + dy * dy + dz * dz;
        pp = px * px + py * py + pz * pz;
        r2 = t_wint'({1'b0, sph_r}) * t_wint'({1'b0, sph_r});
        disc = dp * dp - dd * (pp - r2);
        if (disc >= 0 && dd != 0) begin
            s = int_sqrt(disc);
            t = floor_div((-dp - s) <<< rsi_pkg::FRAC_BITS, dd);
            if (t >= lo && t <= hi) h.hit = 1;
            else begin
                t = floor_div((-dp + s) <<< rsi_pkg::FRAC_BITS, dd);
                h.hit = (t >= lo && t <= hi);
            end
            if (h.hit) h.t = t[rsi_pkg::CW-1:0];
        end
        return h;
    endfunction

    function automatic t_coord sat32(logic signed [35:0] v);
        if (v > 36'sd2147483647) return 32'sh7fffffff;
        if (v < -36'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic t_coord rnd_word();
        return t_coord'($urandom());
    endfunction

    // aimed rays start near the centre and point back at it, so most of them hit
    function automatic t_ray make_ray(bit aimed);
        t_ray r;
        logic signed [35:0] off [3];
        if (!aimed) begin
            r.ox = rnd_word(); r.oy = rnd_word(); r.oz = rnd_word();
            r.dx = rnd_word(); r.dy = rnd_word(); r.dz = rnd_word();
            r.tmin = rnd_word(); r.tmax = rnd_word();
            return r;
        end
        for (int k = 0; k < 3; k++)
            off[k] = 36'($signed($urandom_range(0, 1 << 23))) - 36'sd4194304;
        r.ox = sat32(36'(sph_cx) + off[0]);
        r.oy = sat32(36'(sph_cy) + off[1]);
        r.oz = sat32(36'(sph_cz) + off[2]);
        r.dx = sat32(-off[0] + 36'($signed($urandom_range(0, 4095))) - 36'sd2048);
        r.dy = sat32(-off[1] + 36'($signed($urandom_range(0, 4095))) - 36'sd2048);
        r.dz = sat32(-off[2] + 36'($signed($urandom_range(0, 4095))) - 36'sd2048);
        case ($urandom_range(0, 4))
            0: begin r.tmin = rnd_word(); r.tmax = rnd_word(); end
            1: begin r.tmin = 0; r.tmax = 32'sh7fffffff; end
            default: begin
                r.tmin = t_coord'($signed($urandom_range(0, 1 << 17))) - 32'sd65536;
                r.tmax = t_coord'($urandom_range(0, 1 << 18));
            end
        endcase
        return r;
    endfunction

    function automatic t_ray ray_of(t_coord ox, oy, oz, dx, dy, dz, tmin, tmax);
        t_ray r;
        r.ox = ox; r.oy = oy; r.oz = oz;
        r.dx = dx; r.dy = dy; r.dz = dz;
        r.tmin = tmin; r.tmax = tmax;
        return r;
    endfunction

    task automatic report(string what, t_coord got, t_coord want);
        $display("mismatch in %s: got %0d want %0d", what, got, want);
        errors++;
    endtask

    task automatic write_reg(rsi_pkg::t_cfg_idx idx, logic [rsi_pkg::CW-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            rsi_pkg::CFG_CENTER_X: sph_cx = data;
            rsi_pkg::CFG_CENTER_Y: sph_cy = data;
            rsi_pkg::CFG_CENTER_Z: sph_cz = data;
            rsi_pkg::CFG_RADIUS:   sph_r  = data[rsi_pkg::RADW-1:0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (pending_rays.size() != 0 || i_valid || expected_hits.size() != 0);
        repeat (130) @(posedge i_clk);
    endtask

    task automatic random_rays(int n);
        for (int i = 0; i < n; i++)
            pending_rays.push_back(make_ray($urandom_range(0, 9) < 7));
    endtask

    localparam t_coord ONE = 32'sd65536;

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;

        // unit sphere at the origin after reset
        pending_rays.push_back(ray_of(-3*ONE, 0, 0, ONE, 0, 0, 0, 10*ONE));
        pending_rays.push_back(ray_of(-3*ONE, 0, 0, ONE, 0, 0, 5*ONE/2, 10*ONE));
        pending_rays.push_back(ray_of(-3*ONE, 0, 0, ONE, 0, 0, 0, ONE));
        pending_rays.push_back(ray_of(-3*ONE, 5*ONE, 0, ONE, 0, 0, 0, 10*ONE));
        pending_rays.push_back(ray_of(-3*ONE, ONE, 0, ONE, 0, 0, 0, 10*ONE));
        pending_rays.push_back(ray_of(0, 0, 0, 0, 0, 0, -10*ONE, 10*ONE));
        pending_rays.push_back(ray_of(-3*ONE, 0, 0, ONE, 0, 0, 10*ONE, 0));
        pending_rays.push_back(ray_of(0, 0, 0, ONE, 0, 0, 0, 10*ONE));
        pending_rays.push_back(ray_of(0, 0, 3*ONE, 0, 0, -2*ONE, 0, 10*ONE));
        pending_rays.push_back(ray_of(0, 0, 0, 0, ONE, 0, 32'sh80000000, 32'sh7fffffff));
        pending_rays.push_back(ray_of(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
            32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
        pending_rays.push_back(ray_of(32'sh80000000, 32'sh80000000, 32'sh80000000,
            32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000));
        pending_rays.push_back(ray_of(-1, -1, -1, -1, -1, -1, -1, -1));
        pending_rays.push_back(ray_of(32'sh80000000, 0, 0, 32'sh7fffffff, 0, 0,
            32'sh80000000, 32'sh7fffffff));
        pending_rays.push_back(ray_of(0, 0, 0, 1, 0, 0, 32'sh80000000, 32'sh7fffffff));
        random_rays(180);
        drain();

        // extremes of the registers
        write_reg(rsi_pkg::CFG_CENTER_X, 32'h7fffffff);
        write_reg(rsi_pkg::CFG_CENTER_Y, 32'h7fffffff);
        write_reg(rsi_pkg::CFG_CENTER_Z, 32'h7fffffff);
        write_reg(rsi_pkg::CFG_RADIUS, 32'h7fffffff);
        random_rays(180);
        drain();
        write_reg(rsi_pkg::CFG_CENTER_X, 32'h80000000);
        write_reg(rsi_pkg::CFG_CENTER_Y, 32'h80000000);
        write_reg(rsi_pkg::CFG_CENTER_Z, 32'h80000000);
        write_reg(rsi_pkg::CFG_RADIUS, 32'h0);
        random_rays(180);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            write_reg(rsi_pkg::CFG_CENTER_X,
                      t_coord'($signed($urandom_range(0, 1 << 24))) - (1 << 23));
            write_reg(rsi_pkg::CFG_CENTER_Y,
                      t_coord'($signed($urandom_range(0, 1 << 24))) - (1 << 23));
            write_reg(rsi_pkg::CFG_CENTER_Z,
                      t_coord'($signed($urandom_range(0, 1 << 24))) - (1 << 23));
            // top bit set on purpose in one phase: it must be dropped
            write_reg(rsi_pkg::CFG_RADIUS,
                      (ph == 1) ? 32'h8000_0000 | $urandom_range(1 << 16, 1 << 22)
                                : $urandom_range(1 << 14, 1 << 22));
            if (ph == 1) hold_req = 1;
            if (ph == 4) quiet = 1;
            random_rays(170);
            drain();
        end

        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
        end else if (!i_valid || o_ready) begin
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                i_valid <= 0;
            end else if (pending_rays.size() != 0) begin
                t_ray r;
                r = pending_rays.pop_front();
                i_valid <= 1;
                i_origin_x <= r.ox; i_origin_y <= r.oy; i_origin_z <= r.oz;
                i_dir_x <= r.dx; i_dir_y <= r.dy; i_dir_z <= r.dz;
                i_t_min <= r.tmin; i_t_max <= r.tmax;
                if (!quiet && $urandom_range(0, 11) == 0) tx_gap <= $urandom_range(1, 19);
            end else begin
                i_valid <= 0;
            end
        end
    end

    // receiver, with one long hold-off to fill the pipe
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1;
            hold_left <= 400;
            i_ready <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready <= 0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            i_ready <= 0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rx_gap <= $urandom_range(0, 18);
            i_ready <= 0;
        end else begin
            i_ready <= 1;
        end
    end

    // predict on each accepted ray, check each accepted result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            bit moved;
            moved = 0;
            if (i_valid && o_ready) begin
                expected_hits.push_back(sphere_hit(ray_of(i_origin_x, i_origin_y, i_origin_z,
                    i_dir_x, i_dir_y, i_dir_z, i_t_min, i_t_max)));
                moved = 1;
            end
            if (o_valid && i_ready) begin
                moved = 1;
                if (expected_hits.size() == 0) begin
                    report("unexpected beat", o_hit_t, 0);
                end else begin
                    t_hit want;
                    want = expected_hits.pop_front();
                    if (o_hit_valid !== want.hit)
                        report("hit_valid", t_coord'(o_hit_valid), t_coord'(want.hit));
                    if (o_hit_t !== want.t)
                        report("hit_t", o_hit_t, want.t);
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

endmodule
